// ===== rtl/ctw_pkg.sv =====
package ctw_pkg;

	// Window geometry
	localparam int WINDOW   = 5;
	localparam int MAX_LINE = 1024;
	localparam int OFFSET   = WINDOW / 2;
	localparam int AREA     = WINDOW * WINDOW;
	localparam int LINES    = WINDOW - 1;
	localparam int CENTRE   = OFFSET * WINDOW + OFFSET;
	localparam int WORD_W   = AREA - 1;

	// Field and register widths
	localparam int PIXEL_W   = 8;
	localparam int CENSUS_W  = 24;
	localparam int WIDTH_W   = 10;
	localparam int HEIGHT_W  = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int COL_W     = WIDTH_W + 1;
	localparam int ROW_W     = HEIGHT_W + 1;
	localparam int LINE_AW   = $clog2(MAX_LINE);
	localparam int BANK_W    = (LINES > 1) ? $clog2(LINES) : 1;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// Output queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIXEL_W-1:0] pixel_t;

	typedef struct packed {
		logic [CENSUS_W-1:0] census_word;
		logic                frame_end;
	} ctw_result_t;

	typedef struct packed {
		logic clear;
		logic advance;
	} cell_ctrl_t;

	// Bank that holds the line k rows above the row whose bank is wrb.
	function automatic logic [BANK_W-1:0] bank_of(input logic [BANK_W-1:0] wrb, input int k);
		int t;
		t = int'(wrb) - k;
		if (t < 0) begin
			t = t + LINES;
		end
		return BANK_W'(t);
	endfunction

endpackage

// ===== rtl/ctw_stream_if.sv =====
interface ctw_pixel_if;
	logic            valid;
	logic            ready;
	ctw_pkg::pixel_t pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface ctw_census_if;
	logic                            valid;
	logic                            ready;
	logic [ctw_pkg::CENSUS_W-1:0]    census_word;
	logic                            frame_end;

	modport source (output valid, output census_word, output frame_end, input ready);
	modport sink (input valid, input census_word, input frame_end, output ready);
endinterface

// ===== rtl/ctw_line_bank.sv =====
module ctw_line_bank (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ctw_pkg::LINE_AW-1:0]   waddr,
	input  ctw_pkg::pixel_t               wdata,
	input  logic                          re,
	input  logic [ctw_pkg::LINE_AW-1:0]   raddr,
	output ctw_pkg::pixel_t               rdata
);
	import ctw_pkg::*;

	pixel_t store [MAX_LINE];
	pixel_t rdata_q;

	// read returns the old entry when the same address is written
	always_ff @(posedge clk) begin
		if (we) begin
			store[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= store[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ctw_cell.sv =====
module ctw_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ctw_pkg::cell_ctrl_t ctrl,
	input  ctw_pkg::pixel_t     shift_in,
	input  ctw_pkg::pixel_t     centre,
	input  logic                keep,
	output ctw_pkg::pixel_t     pixel,
	output logic                census_bit
);
	import ctw_pkg::*;

	pixel_t pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q <= '0;
		end else if (ctrl.clear) begin
			pixel_q <= '0;
		end else if (ctrl.advance) begin
			pixel_q <= shift_in;
		end
	end

	assign pixel = pixel_q;
	// masked neighbour reads as zero, and zero is never above the centre
	assign census_bit = keep ? (pixel_q <= centre) : 1'b1;

endmodule

// ===== rtl/ctw_out_queue.sv =====
module ctw_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ctw_pkg::ctw_result_t push_data,
	ctw_census_if.source         census
);
	import ctw_pkg::*;

	ctw_result_t          entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     fill_q;
	logic                 pop;
	ctw_result_t          head;

	assign head        = entry_q[rd_ptr_q];
	assign census.valid       = (fill_q != '0);
	assign census.census_word = head.census_word;
	assign census.frame_end   = head.frame_end;
	assign pop = census.valid && census.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== rtl/census_transform_window.sv =====
// Pipeline: the census beat of a pixel accepted at one clock edge reaches the output
//   through the line store read at the accepting edge, the window shift and the queue write.
// Throughput: one pixel per cycle while a queue slot is free; the four-entry output queue
//   absorbs the beats in flight while the sink stalls.
// Reset: scan position and window cleared, frame size 640 x 480, queue empty; the line
//   store is not cleared and needs no clearing pass.
module census_transform_window (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ctw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctw_pkg::CFG_W-1:0]       cfg_data,
	ctw_pixel_if.sink                       pixels,
	ctw_census_if.source                    census
);
	import ctw_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [WIDTH_W-1:0]  frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_W'(RESET_WIDTH);
			frame_height_q <= HEIGHT_W'(RESET_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: scan position over the padded raster
	// ------------------------------------------------------------------
	logic [COL_W-1:0]  sc_q, sc_inc, sc_nxt, ext_w;
	logic [ROW_W-1:0]  sr_q, sr_inc, sr_nxt, ext_h;
	logic [BANK_W-1:0] wrb_q, wrb_nxt;
	logic [CNT_W-1:0]  cnt_q;
	logic              accept, emit, frame_end, col_ok, pad;
	pixel_t            px;

	assign ext_w = COL_W'(frame_width_q) + COL_W'(OFFSET);
	assign ext_h = ROW_W'(frame_height_q) + ROW_W'(OFFSET);

	// Hold off new pixels once every queue slot is spoken for by a beat in flight.
	assign pixels.ready = (cnt_q < CNT_W'(FIFO_DEPTH));
	assign accept       = pixels.valid && pixels.ready;

	assign sc_inc    = sc_q + 1'b1;
	assign sr_inc    = sr_q + 1'b1;
	assign emit      = (sr_q >= ROW_W'(OFFSET)) && (sc_q >= COL_W'(OFFSET));
	assign frame_end = (sr_inc == ext_h) && (sc_inc == ext_w);
	assign col_ok    = (32'(sc_q) < MAX_LINE);
	// drop whatever the host sends on the padding positions
	assign pad = (sr_q >= ROW_W'(frame_height_q)) || (sc_q >= COL_W'(frame_width_q));
	assign px  = pad ? '0 : pixels.pixel_value;

	always_comb begin
		sc_nxt  = sc_inc;
		sr_nxt  = sr_q;
		wrb_nxt = wrb_q;
		if (sc_inc >= ext_w) begin
			sc_nxt = '0;
			if (sr_inc >= ext_h) begin
				sr_nxt  = '0;
				wrb_nxt = '0;
			end else begin
				sr_nxt  = sr_inc;
				wrb_nxt = (wrb_q == BANK_W'(LINES - 1)) ? '0 : wrb_q + 1'b1;
			end
		end
	end

	// A configuration write restarts the frame; it wins over a pixel in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q  <= '0;
			sr_q  <= '0;
			wrb_q <= '0;
		end else if (cfg_we) begin
			sc_q  <= '0;
			sr_q  <= '0;
			wrb_q <= '0;
		end else if (accept) begin
			sc_q  <= sc_nxt;
			sr_q  <= sr_nxt;
			wrb_q <= wrb_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Line store: one bank per stored line, all read at the current column,
	// the bank of the current row written with the new pixel.
	// ------------------------------------------------------------------
	pixel_t             bank_rd [LINES];
	logic [LINE_AW-1:0] line_addr;

	assign line_addr = LINE_AW'(sc_q);

	for (genvar b = 0; b < LINES; b++) begin : g_bank
		ctw_line_bank u_bank (
			.clk   (clk),
			.we    (accept && col_ok && (wrb_q == BANK_W'(b))),
			.waddr (line_addr),
			.wdata (px),
			.re    (accept),
			.raddr (line_addr),
			.rdata (bank_rd[b])
		);
	end

	// ------------------------------------------------------------------
	// Stage 1: bank data arrives; build the new right column of the window
	// ------------------------------------------------------------------
	logic              acc_s1, emit_s1, fend_s1, col_ok_s1;
	pixel_t            px_s1;
	logic [COL_W-1:0]  sc_s1;
	logic [ROW_W-1:0]  sr_s1;
	logic [BANK_W-1:0] wrb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1  <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			acc_s1  <= accept && !cfg_we;
			emit_s1 <= accept && !cfg_we && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1     <= px;
			sc_s1     <= sc_q;
			sr_s1     <= sr_q;
			wrb_s1    <= wrb_q;
			col_ok_s1 <= col_ok;
			fend_s1   <= frame_end;
		end
	end

	// new_col[r] feeds window row r; row WINDOW-1 takes the live pixel,
	// row WINDOW-1-k the line k rows up, zero above the frame top.
	pixel_t new_col [WINDOW];

	for (genvar k = 1; k <= LINES; k++) begin : g_col
		assign new_col[WINDOW-1-k] = ((sr_s1 >= ROW_W'(k)) && col_ok_s1) ?
			bank_rd[bank_of(wrb_s1, k)] : '0;
	end
	assign new_col[WINDOW-1] = px_s1;

	// ------------------------------------------------------------------
	// Window: a row of cells per window row; each cell hands its pixel to the
	// left neighbour when an accepted pixel advances the window.
	// ------------------------------------------------------------------
	cell_ctrl_t       cell_ctrl;
	pixel_t           cell_pix  [AREA];
	logic [AREA-1:0]  cell_bit;
	logic [AREA-1:0]  cell_keep;
	pixel_t           centre;

	logic             emit_s2, fend_s2;
	logic [COL_W-1:0] sc_s2;
	logic [ROW_W-1:0] sr_s2;

	assign cell_ctrl.clear   = cfg_we;
	assign cell_ctrl.advance = acc_s1;
	assign centre            = cell_pix[CENTRE];

	for (genvar r = 0; r < WINDOW; r++) begin : g_row
		for (genvar c = 0; c < WINDOW; c++) begin : g_cell
			pixel_t shift_in;
			if (c == WINDOW - 1) begin : g_edge
				assign shift_in = new_col[r];
			end else begin : g_inner
				assign shift_in = cell_pix[r*WINDOW + c + 1];
			end
			// columns left of the frame edge still hold the previous row: mask them
			assign cell_keep[r*WINDOW + c] = (sr_s2 >= ROW_W'(WINDOW - 1 - r)) &&
				(sc_s2 >= COL_W'(WINDOW - 1 - c));

			ctw_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (cell_ctrl),
				.shift_in   (shift_in),
				.centre     (centre),
				.keep       (cell_keep[r*WINDOW + c]),
				.pixel      (cell_pix[r*WINDOW + c]),
				.census_bit (cell_bit[r*WINDOW + c])
			);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: window holds the neighborhood; gather bits in raster order,
	// centre skipped, first neighbour in the top bit.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= emit_s1 && !cfg_we;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_s1) begin
			sc_s2   <= sc_s1;
			sr_s2   <= sr_s1;
			fend_s2 <= fend_s1;
		end
	end

	logic [WORD_W-1:0] word;

	for (genvar i = 0; i < AREA; i++) begin : g_word
		if (i < CENTRE) begin : g_pre
			assign word[WORD_W-1-i] = cell_bit[i];
		end else if (i > CENTRE) begin : g_post
			assign word[WORD_W-i] = cell_bit[i];
		end
	end

	ctw_result_t result;

	assign result.census_word = CENSUS_W'(word);
	assign result.frame_end   = fend_s2;

	// ------------------------------------------------------------------
	// Output queue and its credit count: every emitting pixel holds a slot
	// from acceptance until its beat leaves.
	// ------------------------------------------------------------------
	logic take;

	assign take = census.valid && census.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({accept && emit && !cfg_we, take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	ctw_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s2),
		.push_data (result),
		.census    (census)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("credit count beyond queue depth");

	a_beat_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		census.valid |-> (cnt_q != '0))
		else $error("output beat without a credit");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (sc_q == '0 && sr_q == '0 && wrb_q == '0))
		else $error("configuration write did not restart the scan");

	a_emit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s2 |-> (sr_s2 >= ROW_W'(OFFSET) && sc_s2 >= COL_W'(OFFSET)))
		else $error("census beat for a position without a centre pixel");

endmodule

// ===== test/census_transform_window_tb.sv =====
module census_transform_window_tb;
	import ctw_pkg::*;

	// Pause after the last expected beat: the pipeline depth plus margin.
	localparam int DRAIN_CYCLES   = 12;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int RANDOM_ITEMS   = 250;
	localparam int QUIET_TAIL     = 180;
	localparam int MAX_REPORTS    = 40;

	// Pixel texture of a generated frame.
	typedef enum int {
		TEX_UNIFORM,
		TEX_NEAR,
		TEX_FLAT,
		TEX_EXTREME
	} texture_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ctw_pixel_if pixel_bus ();
	ctw_census_if census_bus ();

	census_transform_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pixel_bus),
		.census    (census_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Pixels waiting to be sent, and census beats owed by the block.
	pixel_t      pixel_backlog[$];
	ctw_result_t expected_census[$];

	int mismatches = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int tx_gap = 0;
	int rx_gap = 0;

	// Shadow of the block: frame size, scan position, window and line store.
	int     model_width  = RESET_WIDTH;
	int     model_height = RESET_HEIGHT;
	int     scan_col = 0;
	int     scan_row = 0;
	pixel_t win_px [AREA];
	pixel_t line_mem [LINES*MAX_LINE];

	task automatic restart_frame();
		for (int i = 0; i < AREA; i++) begin
			win_px[i] = '0;
		end
		scan_col = 0;
		scan_row = 0;
	endtask

	// Advance the shadow by one accepted pixel and queue the census beat it owes.
	task automatic predict_census_beat(input pixel_t raw);
		int ext_w;
		int ext_h;
		int sr;
		int sc;
		pixel_t px;
		pixel_t nb;
		pixel_t centre;
		logic [CENSUS_W-1:0] word;
		ctw_result_t beat;
		ext_w = model_width + OFFSET;
		ext_h = model_height + OFFSET;
		sr = scan_row;
		sc = scan_col;
		// padding positions count as zero whatever the host sends
		px = (sr >= model_height || sc >= model_width) ? '0 : raw;

		for (int r = 0; r < WINDOW; r++) begin
			for (int c = 0; c < WINDOW - 1; c++) begin
				win_px[r*WINDOW + c] = win_px[r*WINDOW + c + 1];
			end
		end
		// right column: the stored lines above, newest at the bottom
		for (int k = 1; k <= LINES; k++) begin
			nb = '0;
			if (sr >= k && sc < MAX_LINE) begin
				nb = line_mem[((sr - k) % LINES)*MAX_LINE + sc];
			end
			win_px[(WINDOW - 1 - k)*WINDOW + WINDOW - 1] = nb;
		end
		win_px[AREA-1] = px;
		if (sc < MAX_LINE) begin
			line_mem[(sr % LINES)*MAX_LINE + sc] = px;
		end

		if (sr >= OFFSET && sc >= OFFSET) begin
			centre = win_px[CENTRE];
			word = '0;
			for (int r = 0; r < WINDOW; r++) begin
				for (int c = 0; c < WINDOW; c++) begin
					if (r != OFFSET || c != OFFSET) begin
						// above the top row or left of column 0 reads as zero
						nb = (sr + r >= WINDOW - 1 && sc + c >= WINDOW - 1) ?
							win_px[r*WINDOW + c] : '0;
						word = {word[CENSUS_W-2:0], (nb <= centre)};
					end
				end
			end
			beat.census_word = word;
			beat.frame_end = (sr + 1 == ext_h && sc + 1 == ext_w);
			expected_census.push_back(beat);
		end

		sc++;
		if (sc >= ext_w) begin
			sc = 0;
			sr++;
			if (sr >= ext_h) begin
				sr = 0;
			end
		end
		scan_col = sc;
		scan_row = sr;
	endtask

	task automatic report_mismatch(input string field, input int unsigned want,
		input int unsigned got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	// Drive: hold a beat until taken, otherwise idle in bursts or send the next pixel.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_bus.valid && pixel_bus.ready) begin
				predict_census_beat(pixel_backlog.pop_front());
			end
			if (pixel_bus.valid && !pixel_bus.ready) begin
				// hold: the beat stays on the bus until the block takes it
			end else if (tx_gap > 0) begin
				tx_gap--;
				pixel_bus.valid <= 1'b0;
			end else if (pixel_backlog.size() != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
				tx_gap = $urandom_range(0, 7);
				pixel_bus.valid <= 1'b0;
			end else if (pixel_backlog.size() != 0) begin
				pixel_bus.valid <= 1'b1;
				pixel_bus.pixel_value <= pixel_backlog[0];
			end else begin
				pixel_bus.valid <= 1'b0;
			end
		end
	end

	// Monitor: check every census beat taken against the oldest expectation.
	always @(posedge clk) begin
		ctw_result_t want;
		if (arst_n) begin
			if (census_bus.valid && census_bus.ready) begin
				if (expected_census.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: unexpected census beat: expected none, got word %0h end %0b",
							$time, census_bus.census_word, census_bus.frame_end);
					end
				end else begin
					want = expected_census.pop_front();
					if (census_bus.census_word !== want.census_word) begin
						report_mismatch("census_word", want.census_word, census_bus.census_word);
					end
					if (census_bus.frame_end !== want.frame_end) begin
						report_mismatch("frame_end", want.frame_end, census_bus.frame_end);
					end
				end
			end
			// stall the sink in bursts
			if (rx_gap > 0) begin
				rx_gap--;
				census_bus.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < rx_stall_pct) begin
				rx_gap = $urandom_range(0, 7);
				census_bus.ready <= 1'b0;
			end else begin
				census_bus.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Write one frame register; the shadow restarts its scan at the same edge.
	task automatic write_frame_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (which == CFG_FRAME_WIDTH) begin
			model_width = value[WIDTH_W-1:0];
		end else begin
			model_height = value[HEIGHT_W-1:0];
		end
		restart_frame();
	endtask

	// Wait until every pixel is sent and every beat is back, then let the pipe empty.
	task automatic drain_block();
		do begin
			@(posedge clk);
		end while (pixel_backlog.size() != 0 || pixel_bus.valid || expected_census.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Queue n pixels of the extended scan from its start; padding gets zero or noise.
	task automatic queue_scan(input int n_items, input texture_t tex, input bit dirty_pad);
		int r;
		int c;
		int ext_w;
		int ext_h;
		int base;
		pixel_t v;
		ext_w = model_width + OFFSET;
		ext_h = model_height + OFFSET;
		r = 0;
		c = 0;
		base = $urandom_range(1, 254);
		repeat (n_items) begin
			if (r >= model_height || c >= model_width) begin
				v = dirty_pad ? pixel_t'($urandom) : '0;
			end else begin
				case (tex)
					TEX_NEAR: v = pixel_t'(base - 1 + $urandom_range(0, 2));
					TEX_FLAT: v = pixel_t'(base);
					TEX_EXTREME: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					default: v = pixel_t'($urandom);
				endcase
			end
			pixel_backlog.push_back(v);
			c++;
			if (c >= ext_w) begin
				c = 0;
				r++;
				if (r >= ext_h) begin
					r = 0;
				end
			end
		end
	endtask

	initial begin
		int random_items;
		int pick;
		int w;
		int h;
		int frames;
		int n;
		bit first_random;
		pixel_t directed_3x3 [25] = '{
			8'd0,   8'd255, 8'd128, 8'd255, 8'd1,
			8'd127, 8'd128, 8'd129, 8'd0,   8'd200,
			8'd255, 8'd0,   8'd128, 8'd77,  8'd0,
			8'd255, 8'd255, 8'd0,   8'd128, 8'd7,
			8'd1,   8'd2,   8'd3,   8'd4,   8'd255
		};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		pixel_bus.valid = 1'b0;
		pixel_bus.pixel_value = '0;
		census_bus.ready = 1'b0;
		restart_frame();
		for (int i = 0; i < LINES*MAX_LINE; i++) begin
			line_mem[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset frame size: run into the third row so the first beats come out.
		tx_idle_pct = 15;
		rx_stall_pct = 15;
		queue_scan(1300, TEX_UNIFORM, 1'b0);
		drain_block();

		// Directed 3x3 frame: extreme pixels, ties with the centre, noise on padding.
		write_frame_reg(CFG_FRAME_WIDTH, 16'd3);
		write_frame_reg(CFG_FRAME_HEIGHT, 16'd3);
		foreach (directed_3x3[i]) begin
			pixel_backlog.push_back(directed_3x3[i]);
		end
		drain_block();

		// Narrow frame, one row; the upper data bits must be dropped by the width field.
		write_frame_reg(CFG_FRAME_WIDTH, 16'hFC10);
		write_frame_reg(CFG_FRAME_HEIGHT, 16'd1);
		queue_scan((model_width + OFFSET)*(model_height + OFFSET), TEX_NEAR, 1'b1);
		drain_block();

		// Tallest frame, one column; stop part way and reconfigure.
		write_frame_reg(CFG_FRAME_WIDTH, 16'd1);
		write_frame_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
		queue_scan(60, TEX_UNIFORM, 1'b1);
		drain_block();

		// Zero width, then zero height: the scan wraps over its padding, no beats.
		write_frame_reg(CFG_FRAME_WIDTH, 16'd0);
		write_frame_reg(CFG_FRAME_HEIGHT, 16'd2);
		queue_scan(30, TEX_UNIFORM, 1'b1);
		drain_block();
		write_frame_reg(CFG_FRAME_HEIGHT, 16'd0);
		queue_scan(10, TEX_UNIFORM, 1'b1);
		drain_block();
		write_frame_reg(CFG_FRAME_WIDTH, 16'd5);
		queue_scan(20, TEX_UNIFORM, 1'b1);
		drain_block();

		// Random phases: mostly small frames, some wide ones, a few degenerate sizes.
		random_items = 0;
		first_random = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items > QUIET_TAIL) begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: tx_idle_pct = 0;
					1: tx_idle_pct = 15;
					default: tx_idle_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0: rx_stall_pct = 0;
					1: rx_stall_pct = 15;
					default: rx_stall_pct = 40;
				endcase
			end

			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 10);
			end else if (pick < 17) begin
				w = $urandom_range(20, 40);
				h = $urandom_range(1, 2);
			end else if (pick < 18) begin
				w = 0;
				h = $urandom_range(0, 4);
			end else if (pick < 19) begin
				w = $urandom_range(0, 6);
				h = 0;
			end else begin
				w = 1;
				h = $urandom_range(1, 3);
			end

			// rewrite one register or both; every write restarts the scan
			pick = first_random ? 0 : $urandom_range(0, 3);
			first_random = 1'b0;
			if (pick != 2) begin
				write_frame_reg(CFG_FRAME_WIDTH,
					$urandom_range(0, 3) == 0 ? {6'($urandom), 10'(w)} : 16'(w));
			end
			if (pick != 1) begin
				write_frame_reg(CFG_FRAME_HEIGHT, 16'(h));
			end

			n = (model_width + OFFSET)*(model_height + OFFSET);
			if (model_width == 0 || model_height == 0) begin
				n = 2*n + $urandom_range(0, 5);
			end else if ($urandom_range(0, 4) == 0) begin
				// cut the frame short; the next write abandons it
				n = $urandom_range(1, n - 1);
			end else begin
				frames = $urandom_range(1, 2);
				n = n*frames;
			end
			queue_scan(n, texture_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
			random_items += n;
			drain_block();
		end

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
